>>> rtl/dfa_pkg.sv
`timescale 1ns / 1ps

package dfa_pkg;

  localparam int MaxStates  = 256;
  localparam int MaxSymbols = 32;

  localparam int FuncW     = 2;
  localparam int SymW      = 8;
  localparam int StateW    = 8;
  localparam int StatusW   = 3;
  localparam int StCntW    = 9;
  localparam int RowW      = $clog2(MaxStates);
  localparam int SymIdxW   = $clog2(MaxSymbols);
  localparam int SymCntW   = $clog2(MaxSymbols + 1);
  localparam int StoreAddrW = RowW + SymIdxW;
  localparam int StoreW    = StateW + 1;

  typedef enum logic [FuncW-1:0] {
    FuncAddSym   = 2'd0,
    FuncInsert   = 2'd1,
    FuncLookup   = 2'd2,
    FuncReserved = 2'd3
  } func_e;

  typedef enum logic [StatusW-1:0] {
    StsOk         = 3'd0,
    StsBadState   = 3'd1,
    StsUnknownSym = 3'd2,
    StsSymExists  = 3'd3,
    StsAlphaFull  = 3'd4
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic accept;
    logic load_mem;
  } dfa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic need_read;
    logic out_busy;
  } dfa_sts_t;

endpackage

>>> rtl/dfa_ctrl.sv
`timescale 1ns / 1ps

module dfa_ctrl
  import dfa_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dfa_sts_t sts_i,
  output dfa_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    StClear = 3'b001,
    StIdle  = 3'b010,
    StRead  = 3'b100
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic        ready;

  assign ready      = (state_q == StIdle) && !sts_i.out_busy;
  assign in_ready_o = ready;

  always_comb begin
    state_d         = state_q;
    cmd_o.clear    = 1'b0;
    cmd_o.accept   = 1'b0;
    cmd_o.load_mem = 1'b0;
    unique case (state_q)
      StClear: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        cmd_o.accept = ready && in_valid_i;
        if (ready && in_valid_i && sts_i.need_read) begin
          state_d = StRead;
        end
      end
      StRead: begin
        cmd_o.load_mem = 1'b1;
        state_d        = StIdle;
      end
      default: begin
        state_d = StClear;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/dfa_datapath.sv
`timescale 1ns / 1ps

module dfa_datapath
  import dfa_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [StCntW-1:0]  cfg_wdata_i,
  input  logic [FuncW-1:0]   func_i,
  input  logic [SymW-1:0]    symbol_i,
  input  logic [StateW-1:0]  from_state_i,
  input  logic [StateW-1:0]  to_state_i,
  input  dfa_cmd_t           cmd_i,
  output dfa_sts_t           sts_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [StatusW-1:0] status_o,
  output logic [StateW-1:0]  next_state_o,
  output logic               is_trap_o
);

  logic [StCntW-1:0]     state_count_q;
  logic [StCntW-1:0]     lim;
  logic [SymW-1:0]       sym_tbl_q [MaxSymbols];
  logic [SymCntW-1:0]    sym_cnt_q;
  logic [MaxSymbols-1:0] hit;
  logic [SymIdxW-1:0]    col;
  logic                  any_hit;
  logic                  from_ok;
  logic                  to_ok;
  logic                  sym_full;

  logic [StoreW-1:0]     store_mem [MaxStates*MaxSymbols];
  logic [StoreW-1:0]     rd_q;
  logic [StoreAddrW-1:0] clr_cnt_q;
  logic [StoreAddrW-1:0] item_addr;
  logic [StoreAddrW-1:0] wr_addr;
  logic [StoreW-1:0]     wr_data;
  logic                  wr_en;

  status_e               item_status;
  logic                  item_trap;
  logic                  add_ok;
  logic                  ins_ok;
  logic                  need_read;

  logic                  out_valid_q;
  status_e               status_q;
  logic [StateW-1:0]     next_q;
  logic                  trap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_count_q <= '0;
    end else if (cfg_we_i) begin
      state_count_q <= cfg_wdata_i;
    end
  end

  // limit is the smaller of the register and the table depth
  assign lim = (state_count_q > StCntW'(MaxStates)) ? StCntW'(MaxStates) : state_count_q;
  assign from_ok = {1'b0, from_state_i} < lim;
  assign to_ok   = {1'b0, to_state_i} < lim;
  assign sym_full = sym_cnt_q >= SymCntW'(MaxSymbols);

  // parallel compare against the live part of the alphabet, symbols are unique
  always_comb begin
    col = '0;
    for (int i = 0; i < MaxSymbols; i++) begin
      hit[i] = (SymCntW'(i) < sym_cnt_q) && (sym_tbl_q[i] == symbol_i);
      col    = col | (hit[i] ? SymIdxW'(i) : '0);
    end
  end
  assign any_hit   = |hit;
  assign item_addr = {from_state_i[RowW-1:0], col};

  always_comb begin
    item_status = StsOk;
    item_trap   = 1'b0;
    add_ok      = 1'b0;
    ins_ok      = 1'b0;
    need_read   = 1'b0;
    unique case (func_e'(func_i))
      FuncAddSym: begin
        if (any_hit) begin
          item_status = StsSymExists;
        end else if (sym_full) begin
          item_status = StsAlphaFull;
        end else begin
          add_ok = 1'b1;
        end
      end
      FuncInsert: begin
        if (!from_ok) begin
          item_status = StsBadState;
        end else if (!any_hit) begin
          item_status = StsUnknownSym;
        end else if (!to_ok) begin
          item_status = StsBadState;
        end else begin
          ins_ok = 1'b1;
        end
      end
      FuncLookup: begin
        if (!from_ok) begin
          item_status = StsBadState;
        end else if (!any_hit) begin
          item_trap = 1'b1;
        end else begin
          need_read = 1'b1;
        end
      end
      FuncReserved: begin
        item_status = StsOk;
      end
      default: begin
        item_status = StsOk;
      end
    endcase
  end

  // symbol table has no reset, entries at or above the count are never compared
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && add_ok) begin
      sym_tbl_q[sym_cnt_q[SymIdxW-1:0]] <= symbol_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_cnt_q <= '0;
    end else if (cmd_i.accept && add_ok) begin
      sym_cnt_q <= sym_cnt_q + SymCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear) begin
      clr_cnt_q <= clr_cnt_q + StoreAddrW'(1);
    end
  end

  // store entry is {valid, target}; the clearing pass writes all zeros
  assign wr_en   = cmd_i.clear || (cmd_i.accept && ins_ok);
  assign wr_addr = cmd_i.clear ? clr_cnt_q : item_addr;
  assign wr_data = cmd_i.clear ? '0 : {1'b1, to_state_i};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && need_read) begin
      rd_q <= store_mem[item_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((cmd_i.accept && !need_read) || cmd_i.load_mem) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_mem) begin
      status_q <= StsOk;
      next_q   <= rd_q[StoreW-1] ? rd_q[StateW-1:0] : '0;
      trap_q   <= !rd_q[StoreW-1];
    end else if (cmd_i.accept && !need_read) begin
      status_q <= item_status;
      next_q   <= '0;
      trap_q   <= item_trap;
    end
  end

  assign sts_o.clear_last = &clr_cnt_q;
  assign sts_o.need_read  = need_read;
  assign sts_o.out_busy   = out_valid_q && !out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign next_state_o = next_q;
  assign is_trap_o    = trap_q;

endmodule

>>> rtl/dfa_transition_table.sv
`timescale 1ns / 1ps

// Programmable DFA transition table.
// Request channel (s_axis): tuser carries the operation (add symbol, insert
// transition, lookup); tdata carries symbol, from_state and to_state.
// Result channel (m_axis): one result per request; tdata is the next state,
// tuser holds the status code and the trap flag.
// cfg_we_i / cfg_wdata_i write the state count; write it only while idle.
// Results: add symbol, insert, and lookups that fail or miss the alphabet
// give their result in the cycle after acceptance. A lookup that reads the
// transition store goes through the registered read of the single store
// memory, then the output register; no request is taken during that read.
// Throughput: 1 request per cycle while the result is not stalled; store
// lookups hold off the next request. Reset: the store (8192 entries) is
// cleared to trap by a pass over every entry, during which s_axis_tready_o
// stays low; the alphabet and the state count reset to empty and zero.
// Stall: the result sits in an output register; a new request is taken in
// the cycle the result leaves, and s_axis_tready_o drops while it waits.

module dfa_transition_table
  import dfa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [StCntW-1:0] cfg_wdata_i,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [23:0]       s_axis_tdata_i,   // symbol, from_state, to_state
  input  logic [1:0]        s_axis_tuser_i,   // func
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [7:0]        m_axis_tdata_o,   // next_state
  output logic [3:0]        m_axis_tuser_o    // status, is_trap
);

  dfa_cmd_t           cmd;
  dfa_sts_t           sts;
  logic [StatusW-1:0] status;
  logic               is_trap;

  dfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dfa_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .func_i       (s_axis_tuser_i),
    .symbol_i     (s_axis_tdata_i[7:0]),
    .from_state_i (s_axis_tdata_i[15:8]),
    .to_state_i   (s_axis_tdata_i[23:16]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .status_o     (status),
    .next_state_o (m_axis_tdata_o),
    .is_trap_o    (is_trap)
  );

  assign m_axis_tuser_o = {is_trap, status};

  // no request while the store is being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clear |-> !s_axis_tready_o)
    else $error("request taken during clearing pass");

  // a store lookup always delivers its read in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.accept && sts.need_read) |=> (cmd.load_mem && !s_axis_tready_o))
    else $error("store read not followed by result load");

  // a stalled result blocks new requests
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |-> !cmd.accept)
    else $error("request accepted over a stalled result");

  // trap results carry no state and are always ok
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[3]) |->
      (m_axis_tdata_o == '0 && m_axis_tuser_o[2:0] == StsOk))
    else $error("trap result with state or error");

endmodule

>>> test/tb_dfa_transition_table.sv
`timescale 1ns / 1ps

module tb_dfa_transition_table;
  import dfa_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldAt     = 60;
  localparam int unsigned HoldLen    = 300;

  typedef struct packed {
    status_e    status;
    logic [7:0] next_state;
    logic       is_trap;
  } dfa_result_t;

  class dfa_scoreboard;
    int unsigned state_count;
    logic [7:0]  alphabet[$];
    bit [8:0]    trans_mem [MaxStates*MaxSymbols];  // bit 8 marks a set entry
    dfa_result_t expected_q[$];
    int unsigned accepted;
    int unsigned errors;

    function new();
      state_count = 0;
      accepted    = 0;
      errors      = 0;
      foreach (trans_mem[i]) trans_mem[i] = '0;
    endfunction

    function bit state_valid(logic [7:0] s);
      int unsigned lim;
      lim = (state_count > MaxStates) ? MaxStates : state_count;
      return s < lim;
    endfunction

    function int find_col(logic [7:0] sym);
      foreach (alphabet[i]) if (alphabet[i] == sym) return i;
      return -1;
    endfunction

    function void note_request(func_e f, logic [7:0] sym, logic [7:0] from,
                               logic [7:0] to);
      dfa_result_t r;
      int col;
      r   = '{status: StsOk, next_state: 8'd0, is_trap: 1'b0};
      col = find_col(sym);
      accepted++;
      case (f)
        FuncAddSym: begin
          if (col >= 0) r.status = StsSymExists;
          else if (alphabet.size() >= MaxSymbols) r.status = StsAlphaFull;
          else alphabet.push_back(sym);
        end
        FuncInsert: begin
          if (!state_valid(from)) r.status = StsBadState;
          else if (col < 0) r.status = StsUnknownSym;
          else if (!state_valid(to)) r.status = StsBadState;
          else trans_mem[{from, col[4:0]}] = {1'b1, to};
        end
        FuncLookup: begin
          if (!state_valid(from)) begin
            r.status = StsBadState;
          end else if (col < 0 || !trans_mem[{from, col[4:0]}][8]) begin
            r.is_trap = 1'b1;
          end else begin
            r.next_state = trans_mem[{from, col[4:0]}][7:0];
          end
        end
        default: ;
      endcase
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      $display("error at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [7:0] data, logic [3:0] user);
      dfa_result_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing pending: data %h user %h", data, user));
      end else begin
        e = expected_q.pop_front();
        if (user[2:0] !== e.status)
          report($sformatf("status %0d, want %0d", user[2:0], e.status));
        if (data !== e.next_state)
          report($sformatf("next_state %0d, want %0d", data, e.next_state));
        if (user[3] !== e.is_trap)
          report($sformatf("is_trap %b, want %b", user[3], e.is_trap));
      end
    endtask
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we = 1'b0;
  logic [StCntW-1:0] cfg_wdata = '0;
  logic              req_valid = 1'b0;
  logic [23:0]       req_data = '0;
  logic [1:0]        req_func = '0;
  logic              rsp_ready = 1'b0;
  logic              s_axis_tready_o;
  logic              m_axis_tvalid_o;
  logic [7:0]        m_axis_tdata_o;
  logic [3:0]        m_axis_tuser_o;

  int unsigned src_idle_pct = 0;
  int unsigned dst_idle_pct = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned cycles = 0;

  dfa_scoreboard sb = new();

  dfa_transition_table dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(req_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (req_data),
    .s_axis_tuser_i (req_func),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(rsp_ready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result side: check, then pick the next ready, with one long hold-off
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && rsp_ready)
      sb.check_result(m_axis_tdata_o, m_axis_tuser_o);
    if (!hold_done && sb.accepted >= HoldAt) begin
      hold_left = HoldLen;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= dst_idle_pct);
    end
  end

  task automatic issue_req(func_e f, logic [7:0] sym, logic [7:0] from, logic [7:0] to);
    while ($urandom_range(99) < src_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk_i);
    end
    req_valid <= 1'b1;
    req_func  <= f;
    req_data  <= {to, from, sym};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_request(f, sym, from, to);
  endtask

  // drop valid and wait for every pending result, then let the block settle
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_state_count(int unsigned value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value[StCntW-1:0];
    @(posedge clk_i);
    sb.state_count = value;
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_state();
    int unsigned lim;
    int unsigned r;
    lim = (sb.state_count > MaxStates) ? MaxStates : sb.state_count;
    r   = $urandom_range(99);
    if (lim == 0 || r < 10) return 8'($urandom_range(255));
    if (r < 18) return 8'((lim < MaxStates) ? lim : 255);  // one past the last state, or the last state at full count
    if (r < 26) return 8'(lim - 1);
    return 8'($urandom_range(((lim < 6) ? lim : 6) - 1));
  endfunction

  function automatic logic [7:0] pick_symbol();
    if (sb.alphabet.size() != 0 && $urandom_range(99) < 80)
      return sb.alphabet[$urandom_range(sb.alphabet.size() - 1)];
    return 8'($urandom_range(255));
  endfunction

  task automatic random_reqs(int unsigned n);
    int unsigned r;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 12) issue_req(FuncAddSym, ($urandom_range(99) < 30) ? pick_symbol()
                                         : 8'($urandom_range(255)),
                            8'($urandom_range(255)), 8'($urandom_range(255)));
      else if (r < 45) issue_req(FuncInsert, pick_symbol(), pick_state(), pick_state());
      else if (r < 95) issue_req(FuncLookup, pick_symbol(), pick_state(),
                                 8'($urandom_range(255)));
      else issue_req(FuncReserved, 8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)));
    end
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // store clearing pass keeps the request side closed
    while (!s_axis_tready_o) @(posedge clk_i);
    src_idle_pct = 25;
    dst_idle_pct = 68;

    write_state_count(0);
    issue_req(FuncLookup, 8'h00, 8'h00, 8'h00);
    issue_req(FuncInsert, 8'h00, 8'h00, 8'h00);
    issue_req(FuncAddSym, 8'h00, 8'h00, 8'h00);
    issue_req(FuncAddSym, 8'hff, 8'hff, 8'hff);
    issue_req(FuncAddSym, 8'h00, 8'h12, 8'h34);
    issue_req(FuncReserved, 8'hff, 8'hff, 8'hff);
    drain();

    write_state_count(MaxStates);
    issue_req(FuncInsert, 8'hff, 8'hff, 8'hff);
    issue_req(FuncLookup, 8'hff, 8'hff, 8'h00);
    issue_req(FuncInsert, 8'h5a, 8'h00, 8'h00);
    issue_req(FuncInsert, 8'h00, 8'h00, 8'h00);
    issue_req(FuncLookup, 8'h00, 8'h00, 8'hff);
    issue_req(FuncLookup, 8'hff, 8'h00, 8'h00);   // known symbol, entry never set
    issue_req(FuncLookup, 8'h77, 8'h00, 8'h00);   // symbol not in alphabet
    drain();

    // smaller state count: bad source, unknown symbol, bad target in that order
    write_state_count(2);
    issue_req(FuncInsert, 8'h5a, 8'h02, 8'h05);
    issue_req(FuncInsert, 8'h5a, 8'h01, 8'h05);
    issue_req(FuncInsert, 8'h00, 8'h01, 8'h02);
    issue_req(FuncInsert, 8'h00, 8'h01, 8'h01);
    issue_req(FuncLookup, 8'hff, 8'hff, 8'h00);   // entry kept but state out of range
    issue_req(FuncLookup, 8'h00, 8'h01, 8'h00);
    issue_req(FuncLookup, 8'h00, 8'h00, 8'h00);
    drain();

    write_state_count(MaxStates);
    random_reqs(300);

    src_idle_pct = 68;
    dst_idle_pct = 25;
    write_state_count(12);
    random_reqs(300);

    src_idle_pct = 0;
    dst_idle_pct = 0;
    write_state_count(200);
    random_reqs(200);
    write_state_count(1);
    random_reqs(50);

    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
